// ===== design/assert_macros.svh =====
// Assertion macros shared by the frame receiver modules.
// Include this header with `include; it has no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/wsfr_pkg.sv =====
// Shared types, codes and helpers for the WebSocket frame receiver.
// No dependencies; every design module imports this package.
package wsfr_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048500;

  // Event kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes.
  localparam logic ERR_PROTOCOL  = 1'b0;
  localparam logic ERR_TOO_LARGE = 1'b1;

  // Opcodes that need special handling.
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;

  localparam logic [15:0] CLOSE_NO_STATUS = 16'd1005;

  typedef struct packed {
    logic [1:0]  kind;
    logic        fin;
    logic [3:0]  opcode;
    logic [31:0] length;
    logic [15:0] close_code;
    logic [7:0]  data;
    logic        last;
    logic        err;
  } wsfr_result_t;

  // Mask key bytes are applied most significant first.
  function automatic logic [7:0] mask_byte(input logic [31:0] key, input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0: b = key[31:24];
      2'd1: b = key[23:16];
      2'd2: b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== design/wsfr_parser.sv =====
// Frame parser: header collection, payload unmasking and error detection.
// Depends on wsfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsfr_parser #(
  parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic [31:0]           max_payload_length,
  output logic                  emit,
  output wsfr_pkg::wsfr_result_t result
);
  import wsfr_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;

  // Largest length the length field may carry, clipped to the 32-bit result.
  localparam logic [31:0] LEN_CAP = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << LENGTH_BITS) - 64'd1);

  logic [1:0]  phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [3:0]  header_size, header_size_next;
  logic [7:0]  first_hdr, first_hdr_next;
  logic [7:0]  second_hdr, second_hdr_next;
  logic [31:0] len_acc, len_acc_next;
  logic        len_high, len_high_next;
  logic [31:0] mask_key, mask_key_next;
  logic [15:0] close_acc, close_acc_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [1:0]  mask_pos, mask_pos_next;

  logic [3:0]  op;
  logic        rsv_set, is_ctrl, op_known;
  logic [7:0]  mbyte;
  logic [7:0]  sec_eff;
  logic [6:0]  len7;
  logic [3:0]  ext_bytes;
  logic [4:0]  mstart, cstart, idx;
  logic [3:0]  size_new, size_eff, count_inc;
  logic        ctrl_err;
  logic        in_len, in_mask;
  logic [31:0] acc_upd, mask_upd, len_adj;
  logic        high_upd;
  logic [15:0] close_upd;
  logic [1:0]  mpos_upd;
  logic        hdr_done, too_large;

  assign op       = first_hdr[3:0];
  assign rsv_set  = (first_hdr[6:4] != 3'd0);
  assign is_ctrl  = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  assign op_known = (op <= OP_BINARY) || is_ctrl;
  assign mbyte    = mask_byte(mask_key, mask_pos);

  // The second header byte is used in the cycle it arrives.
  assign sec_eff   = (header_count == 4'd1) ? rx_byte : second_hdr;
  assign len7      = sec_eff[6:0];
  assign ext_bytes = (len7 == LEN7_EXT64) ? 4'd8 : (len7 == LEN7_EXT16) ? 4'd2 : 4'd0;
  assign mstart    = 5'd2 + {1'b0, ext_bytes};
  assign cstart    = mstart + (sec_eff[7] ? 5'd4 : 5'd0);
  assign size_new  = 4'd2 + ext_bytes + (sec_eff[7] ? 4'd4 : 4'd0)
                   + (((op == OP_CLOSE) && (len7 != 7'd0)) ? 4'd2 : 4'd0);
  assign idx       = {1'b0, header_count};
  assign ctrl_err  = is_ctrl && (rsv_set || (len7 > LEN7_CTRL_MAX)
                     || ((op == OP_CLOSE) && (len7 == 7'd1)));

  assign in_len  = (idx < mstart);
  assign in_mask = !in_len && (idx < cstart);

  always_comb begin
    acc_upd   = len_acc;
    high_upd  = len_high;
    mask_upd  = mask_key;
    close_upd = close_acc;
    mpos_upd  = mask_pos;
    if (header_count == 4'd1) begin
      acc_upd  = (len7 >= LEN7_EXT16) ? 32'd0 : {25'd0, len7};
      high_upd = 1'b0;
    end else if (in_len) begin
      // Bits shifted past bit 31 are lost from the 32-bit accumulator, so a sticky flag records them.
      acc_upd  = {len_acc[23:0], rx_byte};
      high_upd = len_high | (len_acc[31:24] != 8'd0);
    end else if (in_mask) begin
      mask_upd = {mask_key[23:0], rx_byte};
    end else begin
      close_upd = {close_acc[7:0], rx_byte ^ mbyte};
      mpos_upd  = mask_pos + 2'd1;
    end
  end

  assign size_eff  = (header_count == 4'd1) ? size_new : header_size;
  assign count_inc = header_count + 4'd1;
  assign hdr_done  = (count_inc >= size_eff);
  // A close frame with a body carries its two-byte code inside the length.
  assign len_adj   = ((op == OP_CLOSE) && (acc_upd != 32'd0)) ? acc_upd - 32'd2 : acc_upd;
  assign too_large = high_upd || (len_adj > max_payload_length) || (len_adj > LEN_CAP);

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    header_size_next     = header_size;
    first_hdr_next       = first_hdr;
    second_hdr_next      = second_hdr;
    len_acc_next         = len_acc;
    len_high_next        = len_high;
    mask_key_next        = mask_key;
    close_acc_next       = close_acc;
    bytes_remaining_next = bytes_remaining;
    mask_pos_next        = mask_pos;
    emit                 = 1'b0;
    result               = '0;
    result.fin           = first_hdr[7];
    result.opcode        = op;
    if (accept) begin
      unique case (phase)
        PH_DATA: begin
          emit                 = 1'b1;
          result.kind          = KIND_PAYLOAD;
          result.data          = rx_byte ^ mbyte;
          result.last          = (bytes_remaining == 32'd1);
          mask_pos_next        = mask_pos + 2'd1;
          bytes_remaining_next = bytes_remaining - 32'd1;
          if (bytes_remaining == 32'd1) begin
            phase_next        = PH_HEADER;
            header_count_next = 4'd0;
            header_size_next  = 4'd2;
          end
        end
        PH_HEADER: begin
          if (header_count == 4'd0) begin
            first_hdr_next    = rx_byte;
            len_acc_next      = 32'd0;
            len_high_next     = 1'b0;
            mask_key_next     = 32'd0;
            close_acc_next    = 16'd0;
            mask_pos_next     = 2'd0;
            header_count_next = 4'd1;
          end else if ((header_count == 4'd1) && ctrl_err) begin
            phase_next  = PH_ERROR;
            emit        = 1'b1;
            result.kind = KIND_ERROR;
            result.err  = ERR_PROTOCOL;
          end else begin
            second_hdr_next   = sec_eff;
            len_acc_next      = acc_upd;
            len_high_next     = high_upd;
            mask_key_next     = mask_upd;
            close_acc_next    = close_upd;
            mask_pos_next     = mpos_upd;
            header_size_next  = size_eff;
            header_count_next = count_inc;
            if (hdr_done) begin
              emit = 1'b1;
              if (too_large || rsv_set || !op_known) begin
                phase_next  = PH_ERROR;
                result.kind = KIND_ERROR;
                result.err  = too_large ? ERR_TOO_LARGE : ERR_PROTOCOL;
              end else begin
                result.kind   = KIND_HEADER;
                result.length = len_adj;
                if (op == OP_CLOSE) begin
                  result.close_code = (len7 == 7'd0) ? CLOSE_NO_STATUS : close_upd;
                end
                if (len_adj == 32'd0) begin
                  header_count_next = 4'd0;
                  header_size_next  = 4'd2;
                end else begin
                  bytes_remaining_next = len_adj;
                  phase_next           = PH_DATA;
                end
              end
            end
          end
        end
        default: begin
          // Error state: bytes are dropped until reset.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= 4'd0;
      header_size     <= 4'd2;
      first_hdr       <= 8'd0;
      second_hdr      <= 8'd0;
      len_acc         <= 32'd0;
      len_high        <= 1'b0;
      mask_key        <= 32'd0;
      close_acc       <= 16'd0;
      bytes_remaining <= 32'd0;
      mask_pos        <= 2'd0;
    end else begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      header_size     <= header_size_next;
      first_hdr       <= first_hdr_next;
      second_hdr      <= second_hdr_next;
      len_acc         <= len_acc_next;
      len_high        <= len_high_next;
      mask_key        <= mask_key_next;
      close_acc       <= close_acc_next;
      bytes_remaining <= bytes_remaining_next;
      mask_pos        <= mask_pos_next;
    end
  end

  `ASSERT_NEXT(a_error_sticky, clk, rst, phase == PH_ERROR, phase == PH_ERROR)
  `ASSERT_SAME(a_count_below_size, clk, rst, phase == PH_HEADER, header_count < header_size)
  `ASSERT_SAME(a_data_has_bytes, clk, rst, phase == PH_DATA, bytes_remaining != 32'd0)

endmodule

// ===== design/wsfr_out_reg.sv =====
// Result register between the parser and the event channel.
// Depends on wsfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsfr_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  wsfr_pkg::wsfr_result_t result_in,
  input  logic                   event_stall,
  output logic                   event_valid,
  output logic                   hold,
  output wsfr_pkg::wsfr_result_t result_q
);
  import wsfr_pkg::*;

  // A new result may enter in the same cycle as the old one is transferred.
  assign hold = event_valid && event_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (load) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

  `ASSERT_SAME(a_no_overwrite, clk, rst, load, !hold)

endmodule

// ===== design/websocket_frame_receiver_top.sv =====
// Channel   Dir  Handshake               Payload
// rx        in   rx_valid / rx_stall     rx_byte
// event     out  event_valid / event_stall  event_kind .. error_code
// cfg       in   cfg_write               cfg_data (max_payload_length)
//
// One byte is taken per cycle while rx is not stalled; its event, if any, is registered in the following cycle.
// The single-pass parser update from stored header state sets this rate.
// Synchronous reset returns the parser to header parsing, empties the result
// register and restores max_payload_length to its default.
// rx is stalled only while a result waits in the register and event is stalled.
// Top level of the frame receiver: the limit register, the parser and the result register.
// Depends on wsfr_pkg, wsfr_parser and wsfr_out_reg.
module websocket_frame_receiver_top #(
  parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [1:0]  event_kind,
  output logic        fin_flag,
  output logic [3:0]  frame_opcode,
  output logic [31:0] payload_length,
  output logic [15:0] close_code,
  output logic [7:0]  data_byte,
  output logic        last_byte,
  output logic        error_code
);
  import wsfr_pkg::*;

  logic [31:0]  max_payload_length;
  logic         accept;
  logic         emit;
  logic         hold;
  wsfr_result_t result_d;
  wsfr_result_t result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      max_payload_length <= cfg_data;
    end
  end

  assign rx_stall = hold;
  assign accept   = rx_valid && !hold;

  wsfr_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .rx_byte            (rx_byte),
    .max_payload_length (max_payload_length),
    .emit               (emit),
    .result             (result_d)
  );

  wsfr_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (emit),
    .result_in   (result_d),
    .event_stall (event_stall),
    .event_valid (event_valid),
    .hold        (hold),
    .result_q    (result_q)
  );

  assign event_kind     = result_q.kind;
  assign fin_flag       = result_q.fin;
  assign frame_opcode   = result_q.opcode;
  assign payload_length = result_q.length;
  assign close_code     = result_q.close_code;
  assign data_byte      = result_q.data;
  assign last_byte      = result_q.last;
  assign error_code     = result_q.err;

endmodule

// ===== dv/wsfr_checker.sv =====
// Checker for the WebSocket frame receiver: follows the parser state from every byte transfer
// and register write, queues the expected events and compares each event transfer with them.
// Depends on wsfr_pkg for the event kinds, opcodes, length codes and the result struct.
module wsfr_checker #(
  parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        event_valid,
  input  logic        event_stall,
  input  logic [1:0]  event_kind,
  input  logic        fin_flag,
  input  logic [3:0]  frame_opcode,
  input  logic [31:0] payload_length,
  input  logic [15:0] close_code,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        error_code,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsfr_pkg::*;

  localparam logic [7:0] RSV_BITS = 8'h70;

  typedef enum logic [1:0] {ST_HEADER, ST_PAYLOAD, ST_HALTED} parse_state_t;

  parse_state_t state;
  int           hdr_pos;
  int           hdr_size;
  logic [7:0]   first_byte;
  logic [7:0]   second_byte;
  logic [63:0]  len_acc;
  logic [31:0]  mask_key;
  logic [15:0]  close_acc;
  logic [31:0]  bytes_left;
  logic [1:0]   mask_pos;
  logic [31:0]  max_len;
  int           mismatches = 0;
  wsfr_result_t expected_events[$];

  function automatic logic [7:0] key_byte();
    return mask_key[8 * (3 - mask_pos) +: 8];
  endfunction

  function automatic int ext_len_bytes(input logic [7:0] second);
    if (second[6:0] == LEN7_EXT64) return 8;
    if (second[6:0] == LEN7_EXT16) return 2;
    return 0;
  endfunction

  task automatic restart_header();
    state = ST_HEADER;
    hdr_pos = 0;
    hdr_size = 2;
  endtask

  task automatic reset_model();
    restart_header();
    max_len = MAX_PAYLOAD_RESET;
    first_byte = '0;
    second_byte = '0;
    len_acc = '0;
    mask_key = '0;
    close_acc = '0;
    bytes_left = '0;
    mask_pos = '0;
  endtask

  task automatic push_event(input logic [1:0] kind, input logic fin, input logic [3:0] op,
                            input logic [31:0] len, input logic [15:0] code,
                            input logic [7:0] data, input logic last, input logic err);
    wsfr_result_t r;
    r.kind = kind;
    r.fin = fin;
    r.opcode = op;
    r.length = len;
    r.close_code = code;
    r.data = data;
    r.last = last;
    r.err = err;
    expected_events.push_back(r);
  endtask

  // An error ends parsing for good; only a reset brings the parser back.
  task automatic flag_error(input logic err);
    state = ST_HALTED;
    push_event(KIND_ERROR, first_byte[7], first_byte[3:0], '0, '0, '0, 1'b0, err);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [3:0]  op;
    logic [6:0]  len7;
    logic [63:0] len;
    logic [63:0] cap;
    logic [15:0] code;
    logic [7:0]  d;
    logic        ctrl;
    int          mstart;
    int          cstart;
    if (state == ST_HALTED) return;
    if (state == ST_PAYLOAD) begin
      d = b ^ key_byte();
      mask_pos = mask_pos + 2'd1;
      bytes_left = bytes_left - 32'd1;
      push_event(KIND_PAYLOAD, first_byte[7], first_byte[3:0], '0, '0, d,
                 bytes_left == 0, 1'b0);
      if (bytes_left == 0) restart_header();
      return;
    end
    if (hdr_pos == 0) begin
      first_byte = b;
      len_acc = '0;
      mask_key = '0;
      close_acc = '0;
      mask_pos = '0;
      hdr_pos = 1;
      return;
    end
    op = first_byte[3:0];
    ctrl = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    if (hdr_pos == 1) begin
      second_byte = b;
      len7 = b[6:0];
      if (ctrl && ((first_byte & RSV_BITS) != 0 || len7 > LEN7_CTRL_MAX ||
                   (op == OP_CLOSE && len7 == 7'd1))) begin
        flag_error(ERR_PROTOCOL);
        return;
      end
      len_acc = (len7 >= LEN7_EXT16) ? 64'd0 : {57'd0, len7};
      hdr_size = 2 + ext_len_bytes(b) + (b[7] ? 4 : 0) +
                 ((op == OP_CLOSE && len7 != 0) ? 2 : 0);
    end else begin
      mstart = 2 + ext_len_bytes(second_byte);
      cstart = mstart + (second_byte[7] ? 4 : 0);
      if (hdr_pos < mstart) begin
        len_acc = {len_acc[55:0], b};
      end else if (hdr_pos < cstart) begin
        mask_key = {mask_key[23:0], b};
      end else begin
        // The close code is masked with the first two key bytes.
        close_acc = {close_acc[7:0], b ^ key_byte()};
        mask_pos = mask_pos + 2'd1;
      end
    end
    hdr_pos++;
    if (hdr_pos < hdr_size) return;

    len = len_acc;
    cap = (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);
    if (cap > {32'd0, max_len}) cap = {32'd0, max_len};
    if (op == OP_CLOSE && len != 0) len = len - 64'd2;
    if (len > cap) begin
      flag_error(ERR_TOO_LARGE);
    end else if ((first_byte & RSV_BITS) != 0) begin
      flag_error(ERR_PROTOCOL);
    end else if (!(op <= OP_BINARY || ctrl)) begin
      flag_error(ERR_PROTOCOL);
    end else begin
      if (op == OP_CLOSE) begin
        code = (second_byte[6:0] == 0) ? CLOSE_NO_STATUS : close_acc;
      end else begin
        code = '0;
      end
      push_event(KIND_HEADER, first_byte[7], op, len[31:0], code, '0, 1'b0, 1'b0);
      if (len == 0) begin
        restart_header();
      end else begin
        bytes_left = len[31:0];
        state = ST_PAYLOAD;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    wsfr_result_t want;
    if (rst) begin
      reset_model();
      expected_events.delete();
    end else begin
      if (event_valid && !event_stall) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          $error("event_kind: expected no event, actual %0d", event_kind);
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 32'(want.kind), 32'(event_kind));
          check_field("fin_flag", 32'(want.fin), 32'(fin_flag));
          check_field("frame_opcode", 32'(want.opcode), 32'(frame_opcode));
          check_field("payload_length", want.length, payload_length);
          check_field("close_code", 32'(want.close_code), 32'(close_code));
          check_field("data_byte", 32'(want.data), 32'(data_byte));
          check_field("last_byte", 32'(want.last), 32'(last_byte));
          check_field("error_code", 32'(want.err), 32'(error_code));
        end
      end
      if (cfg_write) max_len = cfg_data;
      if (rx_valid && !rx_stall) parse_byte(rx_byte);
    end
    pending <= expected_events.size();
    fail_count <= mismatches;
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the frame receiver testbench: clock, reset, frame stimulus, register writes and the
// verdict. Instantiates websocket_frame_receiver_top and wsfr_checker; uses wsfr_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wsfr_pkg::*;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;

  typedef enum int {LEN_IN_HEADER, LEN_EXT16, LEN_EXT64} len_form_t;

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_stall;
  logic [7:0]  rx_byte;
  logic        cfg_write;
  logic [31:0] cfg_data;
  logic        event_valid;
  logic        event_stall;
  logic [1:0]  event_kind;
  logic        fin_flag;
  logic [3:0]  frame_opcode;
  logic [31:0] payload_length;
  logic [15:0] close_code;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        error_code;
  int          fail_count;
  int          pending;
  int unsigned bytes_sent;
  bit          idle_on;

  websocket_frame_receiver_top u_top (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .event_valid(event_valid), .event_stall(event_stall), .event_kind(event_kind),
    .fin_flag(fin_flag), .frame_opcode(frame_opcode), .payload_length(payload_length),
    .close_code(close_code), .data_byte(data_byte), .last_byte(last_byte),
    .error_code(error_code)
  );

  wsfr_checker u_checker (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .event_valid(event_valid), .event_stall(event_stall), .event_kind(event_kind),
    .fin_flag(fin_flag), .frame_opcode(frame_opcode), .payload_length(payload_length),
    .close_code(close_code), .data_byte(data_byte), .last_byte(last_byte),
    .error_code(error_code), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Event side back-pressure in short bursts while idling is allowed.
  initial begin
    event_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        event_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        event_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] hdr0(input logic fin, input logic [2:0] rsv,
                                      input logic [3:0] op);
    return {fin, rsv, op};
  endfunction

  // Mostly short payloads, now and then anything up to the limit or the limit itself.
  function automatic int unsigned pick_len(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 29);
    if (r == 0) return lim;
    if (r < 5) return $urandom_range(0, lim);
    return $urandom_range(0, (lim < 10) ? lim : 10);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] first, input len_form_t form, input bit masked,
                             input logic [31:0] key, input logic [63:0] len_field);
    logic [6:0] len7;
    case (form)
      LEN_EXT16: len7 = LEN7_EXT16;
      LEN_EXT64: len7 = LEN7_EXT64;
      default:   len7 = len_field[6:0];
    endcase
    put_byte(first);
    put_byte({masked, len7});
    if (form == LEN_EXT16) begin
      put_byte(len_field[15:8]);
      put_byte(len_field[7:0]);
    end
    if (form == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) put_byte(len_field[8 * i +: 8]);
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) put_byte(key[8 * i +: 8]);
    end
  endtask

  task automatic send_frame(input logic [7:0] first, input len_form_t form, input bit masked,
                            input logic [31:0] key, input bit with_code,
                            input logic [15:0] code, input int unsigned plen);
    logic [63:0] len_field;
    logic [31:0] eff_key;
    len_field = {32'd0, plen};
    if (with_code) len_field = len_field + 64'd2;
    eff_key = masked ? key : 32'd0;
    send_header(first, form, masked, key, len_field);
    if (with_code) begin
      put_byte(code[15:8] ^ eff_key[31:24]);
      put_byte(code[7:0] ^ eff_key[23:16]);
    end
    repeat (plen) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame(input logic [31:0] cap);
    int unsigned pick;
    int unsigned lim;
    int unsigned plen;
    logic [3:0]  op;
    logic [31:0] key;
    logic [15:0] code;
    bit          fin;
    bit          masked;
    bit          with_code;
    len_form_t   form;
    pick = $urandom_range(0, 9);
    if (pick < 7) op = 4'($urandom_range(0, OP_BINARY));
    else if (pick == 7) op = OP_CLOSE;
    else if (pick == 8) op = OP_PING;
    else op = OP_PONG;
    fin = 1'($urandom_range(0, 1));
    masked = $urandom_range(0, 3) != 0;
    key = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
    code = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    with_code = (op == OP_CLOSE) && ($urandom_range(0, 3) != 0);
    if (op == OP_CLOSE) lim = with_code ? 32'(LEN7_CTRL_MAX) - 32'd2 : 32'd0;
    else if (op == OP_PING || op == OP_PONG) lim = 32'(LEN7_CTRL_MAX);
    else lim = 200;
    if (cap < lim) lim = cap;
    plen = pick_len(lim);
    form = LEN_IN_HEADER;
    if (op <= OP_BINARY) begin
      pick = $urandom_range(0, 5);
      if (plen > LEN7_CTRL_MAX) form = (pick < 3) ? LEN_EXT16 : LEN_EXT64;
      else if (pick == 0) form = LEN_EXT16;
      else if (pick == 1) form = LEN_EXT64;
    end
    send_frame(hdr0(fin, 3'b000, op), form, masked, key, with_code, code, plen);
  endtask

  task automatic random_until(input int unsigned target, input logic [31:0] cap,
                              input bit allow_idle);
    while (bytes_sent < target) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      send_random_frame(cap);
    end
  endtask

  // Hold the sender until every expected event has been taken.
  task automatic settle();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Ends the run with one of the error cases; the parser is dead afterwards.
  task automatic provoke_error(input logic [31:0] cap);
    logic [3:0]  op;
    logic [3:0]  bad_op;
    logic [2:0]  rsv;
    logic [63:0] over;
    logic [31:0] key;
    bit          masked;
    masked = 1'($urandom_range(0, 1));
    key = $urandom;
    rsv = 3'($urandom_range(1, 7));
    op = OP_CLOSE + 4'($urandom_range(0, 2));
    bad_op = 4'($urandom_range(3, 12));
    if (bad_op >= OP_CLOSE) bad_op = bad_op + 4'd3;
    case ($urandom_range(0, 5))
      0: begin
        put_byte(hdr0(1'b1, rsv, op));
        put_byte({masked, 7'd0});
      end
      1: begin
        put_byte(hdr0(1'b1, 3'b000, op));
        put_byte({masked, ($urandom_range(0, 1) != 0) ? LEN7_EXT64 : LEN7_EXT16});
      end
      2: begin
        put_byte(hdr0(1'b1, 3'b000, OP_CLOSE));
        put_byte({masked, 7'd1});
      end
      3: begin
        over = {32'd0, cap} + 64'd1;
        send_header(hdr0(1'b1, 3'b000, OP_BINARY),
                    (over > 65535) ? LEN_EXT64 :
                    (over > LEN7_CTRL_MAX) ? LEN_EXT16 : LEN_IN_HEADER,
                    masked, key, over);
      end
      4: send_header(hdr0(1'b0, rsv, OP_TEXT), LEN_IN_HEADER, masked, key, 64'd0);
      default: send_header(hdr0(1'b1, 3'b000, bad_op), LEN_IN_HEADER, masked, key, 64'd0);
    endcase
  endtask

  initial begin : stimulus
    int unsigned  n;
    logic [31:0]  small_cap;
    logic [31:0]  tail_cap;
    rst <= 1'b1;
    rx_valid <= 1'b0;
    rx_byte <= '0;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-picked frames under the reset limit: every opcode and length form.
    idle_on = 1'b1;
    send_frame(hdr0(1'b0, 3'b000, OP_TEXT), LEN_IN_HEADER, 1'b0, '0, 1'b0, '0, 0);
    send_frame(hdr0(1'b1, 3'b000, OP_BINARY), LEN_IN_HEADER, 1'b1, 32'hA5C3_0FF0,
               1'b0, '0, 3);
    send_frame(hdr0(1'b1, 3'b000, OP_CONT), LEN_EXT16, 1'b0, '0, 1'b0, '0, 1);
    send_frame(hdr0(1'b1, 3'b000, OP_CLOSE), LEN_IN_HEADER, 1'b0, '0, 1'b0, '0, 0);
    send_frame(hdr0(1'b1, 3'b000, OP_CLOSE), LEN_IN_HEADER, 1'b1, 32'hFFFF_FFFF,
               1'b1, 16'd1000, 1);
    send_frame(hdr0(1'b1, 3'b000, OP_PING), LEN_IN_HEADER, 1'b0, '0, 1'b0, '0, 2);
    send_frame(hdr0(1'b1, 3'b000, OP_PONG), LEN_IN_HEADER, 1'b1, '0, 1'b0, '0, 0);
    send_frame(hdr0(1'b0, 3'b000, OP_BINARY), LEN_EXT64, 1'b1, 32'h1234_5678,
               1'b0, '0, 1);

    random_until(300, MAX_PAYLOAD_RESET, 1'b1);
    settle();
    write_limit(32'd0);
    random_until(420, 32'd0, 1'b1);
    settle();
    small_cap = $urandom_range(1, 40);
    write_limit(small_cap);
    random_until(720, small_cap, 1'b1);
    settle();
    write_limit(32'hFFFF_FFFF);
    random_until(1000, 32'hFFFF_FFFF, 1'b1);
    settle();

    case ($urandom_range(0, 2))
      0: tail_cap = 32'd0;
      1: tail_cap = $urandom_range(1, 40);
      default: tail_cap = 32'hFFFF_FFFF;
    endcase
    write_limit(tail_cap);
    random_until(1150, tail_cap, 1'b0);
    idle_on = 1'b0;
    provoke_error(tail_cap);
    // These must all be dropped by the halted parser.
    repeat (12) put_byte(8'($urandom_range(0, 255)));
    rx_valid <= 1'b0;

    @(posedge clk);
    for (n = 0; n < 5000 && pending != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/wsfr_pkg.sv
design/wsfr_parser.sv
design/wsfr_out_reg.sv
design/websocket_frame_receiver_top.sv
dv/wsfr_checker.sv
dv/tb_top.sv
